>>> sv/utf8fsd_pkg.sv
package utf8fsd_pkg;

  localparam int unsigned CpWidth = 21;

  // Direction codes carried on the result channel.
  localparam logic [1:0] DirLtr = 2'd1;
  localparam logic [1:0] DirRtl = 2'd2;

  // Right-to-left ranges.
  localparam logic [CpWidth-1:0] RtlLo0 = 21'h00_0590;
  localparam logic [CpWidth-1:0] RtlHi0 = 21'h00_08FF;
  localparam logic [CpWidth-1:0] RtlLo1 = 21'h00_FB1D;
  localparam logic [CpWidth-1:0] RtlHi1 = 21'h00_FEFF;

  // Left-to-right ranges.
  localparam logic [CpWidth-1:0] LtrLo0 = 21'h00_0041;
  localparam logic [CpWidth-1:0] LtrHi0 = 21'h00_02AF;
  localparam logic [CpWidth-1:0] LtrLo1 = 21'h00_0370;
  localparam logic [CpWidth-1:0] LtrHi1 = 21'h00_058F;
  localparam logic [CpWidth-1:0] LtrLo2 = 21'h00_0900;
  localparam logic [CpWidth-1:0] LtrHi2 = 21'h00_D7AF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [1:0] direction;
    logic       strong_found;
  } out_t;

  typedef struct packed {
    logic [1:0]         bytes_pending;
    logic [CpWidth-1:0] partial_codepoint;
    logic               invalid_lead;
    logic               decided;
    logic               right_to_left;
    logic               stopped;
  } state_t;

  typedef struct packed {
    logic is_strong;
    logic rtl;
  } class_t;

  localparam state_t StateReset = '{
    bytes_pending:     2'd0,
    partial_codepoint: '0,
    invalid_lead:      1'b0,
    decided:           1'b0,
    right_to_left:     1'b0,
    stopped:           1'b0
  };

endpackage

>>> sv/utf8_first_strong_direction_top.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_data_i  (text_byte, end_of_string)
// out      output     out_valid_o / out_stall_i out_data_o (direction, strong_found)
//
// Each byte is registered in the input register and is folded into the
// decoder state when it advances; one byte per cycle is sustained unless
// an end-of-string byte stalls; its result is registered in the output register.
// Reset clears the decoder state and both valid flags; the block is ready at once.
// Only an end-of-string byte waits on a stalled output register; other bytes flow.
module utf8_first_strong_direction_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  utf8fsd_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output utf8fsd_pkg::out_t  out_data_o
);
  import utf8fsd_pkg::*;

  logic   in_vld_q, in_vld_d;
  in_t    in_q;
  logic   out_vld_q, out_vld_d;
  out_t   out_q, out_d;
  state_t state_q, state_d, state_next;
  logic   advance;
  logic   take;

  utf8fsd_step u_step (
    .state_i (state_q),
    .byte_i  (in_q.text_byte),
    .state_o (state_next)
  );

  // The registered byte moves on unless it would produce a result while the
  // previous result is still held.
  assign advance = in_vld_q && !(in_q.end_of_string && out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign take = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    state_d   = state_q;
    if (advance) begin
      if (in_q.end_of_string) begin
        out_vld_d          = 1'b1;
        out_d.direction    = (state_next.decided && state_next.right_to_left) ?
                             DirRtl : DirLtr;
        out_d.strong_found = state_next.decided;
        state_d            = StateReset;
      end else begin
        state_d = state_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= StateReset;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A result is left-to-right whenever no strong character decided it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.strong_found |-> out_data_o.direction == DirLtr)
    else $error("defaulted result is not left-to-right");

  // The decoder never waits for trail bytes once it has decided or stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.decided || state_q.stopped) |-> state_q.bytes_pending == 2'd0)
    else $error("trail bytes pending after decision or stop");

  // An end-of-string transaction leaves the decoder in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.end_of_string |=> state_q == StateReset && out_valid_o)
    else $error("state not cleared or result missing after end of string");

  // The input side stalls only because the output register is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && in_q.end_of_string)
    else $error("input stalled without a held result");

endmodule

>>> sv/utf8fsd_classify.sv
module utf8fsd_classify (
  input  logic [utf8fsd_pkg::CpWidth-1:0] codepoint_i,
  output utf8fsd_pkg::class_t             class_o
);
  import utf8fsd_pkg::*;

  logic in_rtl;
  logic in_ltr;

  assign in_rtl = ((codepoint_i >= RtlLo0) && (codepoint_i <= RtlHi0)) ||
                  ((codepoint_i >= RtlLo1) && (codepoint_i <= RtlHi1));
  assign in_ltr = ((codepoint_i >= LtrLo0) && (codepoint_i <= LtrHi0)) ||
                  ((codepoint_i >= LtrLo1) && (codepoint_i <= LtrHi1)) ||
                  ((codepoint_i >= LtrLo2) && (codepoint_i <= LtrHi2));

  // The right-to-left test wins; the ranges do not overlap anyway.
  assign class_o.is_strong = in_rtl || in_ltr;
  assign class_o.rtl       = in_rtl;

endmodule

>>> sv/utf8fsd_step.sv
module utf8fsd_step (
  input  utf8fsd_pkg::state_t state_i,
  input  logic [7:0]          byte_i,
  output utf8fsd_pkg::state_t state_o
);
  import utf8fsd_pkg::*;

  logic [CpWidth-1:0] shifted;
  logic [CpWidth-1:0] cp_sel;
  logic               cp_check;
  class_t             cls;

  assign shifted = {state_i.partial_codepoint[CpWidth-7:0], byte_i[5:0]};

  // A single-byte character is classified directly; a closing trail byte
  // classifies the assembled value unless the lead byte was invalid.
  always_comb begin
    cp_sel   = '0;
    cp_check = 1'b0;
    if (state_i.bytes_pending == 2'd0) begin
      cp_sel   = {{(CpWidth-8){1'b0}}, byte_i};
      cp_check = !byte_i[7];
    end else begin
      cp_sel   = shifted;
      cp_check = (state_i.bytes_pending == 2'd1) && !state_i.invalid_lead;
    end
  end

  utf8fsd_classify u_classify (
    .codepoint_i (cp_sel),
    .class_o     (cls)
  );

  always_comb begin
    state_o = state_i;
    if (state_i.stopped || state_i.decided) begin
      state_o = state_i;
    end else if (byte_i == 8'h00) begin
      state_o.stopped           = 1'b1;
      state_o.bytes_pending     = 2'd0;
      state_o.partial_codepoint = '0;
      state_o.invalid_lead      = 1'b0;
    end else if (state_i.bytes_pending == 2'd0) begin
      state_o.invalid_lead = 1'b0;
      if (!byte_i[7]) begin
        // Single-byte character: only the classification can change.
      end else if (byte_i[7:5] == 3'b110) begin
        state_o.partial_codepoint = {{(CpWidth-5){1'b0}}, byte_i[4:0]};
        state_o.bytes_pending     = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        state_o.partial_codepoint = {{(CpWidth-4){1'b0}}, byte_i[3:0]};
        state_o.bytes_pending     = 2'd2;
      end else if (byte_i[7:3] == 5'b11110) begin
        state_o.partial_codepoint = {{(CpWidth-3){1'b0}}, byte_i[2:0]};
        state_o.bytes_pending     = 2'd3;
      end else begin
        state_o.partial_codepoint = '0;
        state_o.invalid_lead      = 1'b1;
        state_o.bytes_pending     = 2'd3;
      end
    end else begin
      state_o.bytes_pending = state_i.bytes_pending - 2'd1;
      if (state_i.bytes_pending == 2'd1) begin
        state_o.invalid_lead      = 1'b0;
        state_o.partial_codepoint = '0;
      end else begin
        state_o.partial_codepoint = shifted;
      end
    end
    if (!state_i.stopped && !state_i.decided && (byte_i != 8'h00) &&
        cp_check && cls.is_strong) begin
      state_o.decided       = 1'b1;
      state_o.right_to_left = cls.rtl;
    end
  end

endmodule
